@@ hw/rtl/bmf_pkg.sv @@
// Shared types and constants of the bit map run finder.
package bmf_pkg;

    localparam int WORD_W  = 32;
    localparam int CFG_W   = 11;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 11;
    localparam int HINT_W  = 10;
    localparam int WIDX_W  = 5;
    localparam int START_W = 10;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND_SET  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FIND_CLR  = 2'd3;

    // result select
    localparam logic [1:0] RES_NONE  = 2'd0;
    localparam logic [1:0] RES_READ  = 2'd1;
    localparam logic [1:0] RES_ROUND = 2'd2;
    localparam logic [1:0] RES_RUN   = 2'd3;

    typedef struct packed {
        logic       load;
        logic       wr_item;
        logic       rd_item;
        logic       clr_step;
        logic       scan_init;
        logic       scan_pass;
        logic       scan_rd;
        logic       byte_step;
        logic       flip_rd;
        logic       flip_wr;
        logic       res_set;
        logic [1:0] res_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic n_zero;
        logic too_long;
        logic step_hit;
        logic pass_end;
        logic word_end;
        logic pass2;
        logic flip_last;
    } sts_t;

endpackage

@@ hw/rtl/bmf_if.sv @@
// Valid/ready channel interfaces for item and result beats.
interface bmf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [10:0] run_length;
    logic [9:0]  hint;
    logic [4:0]  word_index;
    logic [31:0] word_data;

    modport source (output valid, kind, run_length, hint, word_index, word_data,
                    input ready);
    modport sink   (input valid, kind, run_length, hint, word_index, word_data,
                    output ready);
endinterface

interface bmf_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [9:0]  run_start;
    logic [31:0] read_word;

    modport source (output valid, found, run_start, read_word, input ready);
    modport sink   (input valid, found, run_start, read_word, output ready);
endinterface

@@ hw/rtl/bmf_ram.sv @@
// Generic single write, single read RAM with registered read data.
module bmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/bmf_ctrl.sv @@
// Controller state machine: sequences clear, word access, run scan and flip.
module bmf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_kind,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bmf_pkg::sts_t     sts,
    output bmf_pkg::cmd_t     cmd
);
    import bmf_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RDD  = 4'd2;
    localparam logic [3:0] S_FCHK = 4'd3;
    localparam logic [3:0] S_SRD  = 4'd4;
    localparam logic [3:0] S_SBY  = 4'd5;
    localparam logic [3:0] S_FRD  = 4'd6;
    localparam logic [3:0] S_FWR  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    case (in_kind)
                        KIND_WRITE:
                        begin
                            cmd.wr_item = 1'b1;
                            cmd.res_set = 1'b1;
                            cmd.res_sel = RES_NONE;
                            state_next  = S_FIN;
                        end
                        KIND_READ:
                        begin
                            cmd.rd_item = 1'b1;
                            state_next  = S_RDD;
                        end
                        default:
                        begin
                            state_next = S_FCHK;
                        end
                    endcase
                end
            end
            S_RDD:
            begin
                cmd.res_set = 1'b1;
                cmd.res_sel = RES_READ;
                state_next  = S_FIN;
            end
            S_FCHK:
            begin
                if (sts.n_zero)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_ROUND;
                    state_next  = S_FIN;
                end
                else if (sts.too_long)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_NONE;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    cmd.scan_pass = 1'b0;
                    state_next    = S_SRD;
                end
            end
            S_SRD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SBY;
            end
            S_SBY:
            begin
                cmd.byte_step = 1'b1;
                if (sts.step_hit)
                begin
                    state_next = S_FRD;
                end
                else if (sts.pass_end)
                begin
                    if (!sts.pass2)
                    begin
                        cmd.scan_init = 1'b1;
                        cmd.scan_pass = 1'b1;
                        state_next    = S_SRD;
                    end
                    else
                    begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_NONE;
                        state_next  = S_FIN;
                    end
                end
                else if (sts.word_end)
                begin
                    state_next = S_SRD;
                end
            end
            S_FRD:
            begin
                cmd.flip_rd = 1'b1;
                state_next  = S_FWR;
            end
            S_FWR:
            begin
                cmd.flip_wr = 1'b1;
                if (sts.flip_last)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_RUN;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_FIN:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/bmf_dp.sv @@
// Datapath: item registers, byte scanner, flip mask, map RAM port and result.
module bmf_dp #(
    parameter int MAP_BITS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bmf_pkg::cmd_t              cmd,
    output bmf_pkg::sts_t              sts,
    input  logic                       cfg_we,
    input  logic [bmf_pkg::CFG_W-1:0]  cfg_data,
    input  logic [bmf_pkg::KIND_W-1:0] in_kind,
    input  logic [bmf_pkg::LEN_W-1:0]  in_run_length,
    input  logic [bmf_pkg::HINT_W-1:0] in_hint,
    input  logic [bmf_pkg::WIDX_W-1:0] in_word_index,
    input  logic [bmf_pkg::WORD_W-1:0] in_word_data,
    output logic                       out_found,
    output logic [bmf_pkg::START_W-1:0] out_run_start,
    output logic [bmf_pkg::WORD_W-1:0] out_read_word
);
    import bmf_pkg::*;

    localparam int MAP_WORDS = MAP_BITS / WORD_W;
    localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SZW = $clog2(MAP_BITS + 1);
    localparam int PW  = ((SZW > CFG_W) ? SZW : CFG_W) + 1;

    // size register and clear sweep counter
    logic [CFG_W-1:0] cfg_reg;
    logic [AW-1:0]    clr_cnt_reg;

    // item registers
    logic [KIND_W-1:0] kind_reg;
    logic [PW-1:0]     n_reg;
    logic [PW-1:0]     hint_reg;
    logic              widx_ok_reg;
    logic [PW-1:0]     base_reg;
    logic [PW-1:0]     run_reg;
    logic              pass_reg;
    logic [PW-1:0]     hitpos_reg;
    logic [AW-1:0]     fw_reg;
    logic [1:0]        res_sel_reg;

    logic              found_reg;
    logic [START_W-1:0] start_reg;
    logic [WORD_W-1:0] rword_reg;

    // RAM port
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic [PW-1:0] size;
    logic [PW-1:0] cfg_ext;
    logic [PW-1:0] hint_ext;
    logic [PW-1:0] lo;
    logic          want;
    logic          widx_ok_live;
    logic          step_hit;
    logic [PW-1:0] step_pos;
    logic [PW-1:0] step_run;
    logic [PW-1:0] run_end;
    logic [WORD_W-1:0] flip_mask;

    assign cfg_ext  = PW'(cfg_reg);
    assign size     = (cfg_ext > PW'(MAP_BITS)) ? PW'(MAP_BITS) : cfg_ext;
    assign hint_ext = PW'(in_hint);
    assign lo       = pass_reg ? '0 : hint_reg;
    assign want     = (kind_reg == KIND_FIND_SET);
    assign widx_ok_live = (32'(in_word_index) < 32'(MAP_WORDS));
    assign run_end  = hitpos_reg + n_reg - PW'(1);

    // one byte of the scan: run counter carried across eight bits
    always_comb
    begin
        logic [PW-1:0] p;
        logic          m;
        step_run = run_reg;
        step_hit = 1'b0;
        step_pos = '0;
        for (int j = 0; j < 8; j++)
        begin
            p = base_reg + PW'(j);
            m = (p >= lo) && (p < size) && (ram_rdata[{base_reg[4:3], 3'(j)}] == want);
            step_run = m ? step_run + PW'(1) : '0;
            if (m && !step_hit && (step_run >= n_reg))
            begin
                step_hit = 1'b1;
                step_pos = p + PW'(1) - n_reg;
            end
        end
    end

    // bits of the current flip word that fall inside the run
    always_comb
    begin
        logic [PW-1:0] p;
        for (int i = 0; i < WORD_W; i++)
        begin
            p = PW'({fw_reg, 5'(i)});
            flip_mask[i] = (p >= hitpos_reg) && (p <= run_end);
        end
    end

    // RAM port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = fw_reg;
        ram_wdata = want ? (ram_rdata & ~flip_mask) : (ram_rdata | flip_mask);
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (cmd.wr_item)
        begin
            ram_we    = widx_ok_live;
            ram_waddr = AW'(in_word_index);
            ram_wdata = in_word_data;
        end
        else if (cmd.flip_wr)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        ram_re    = cmd.rd_item || cmd.scan_rd || cmd.flip_rd;
        ram_raddr = fw_reg;
        if (cmd.rd_item)
        begin
            ram_raddr = AW'(in_word_index);
        end
        else if (cmd.scan_rd)
        begin
            ram_raddr = base_reg[AW+4:5];
        end
    end

    bmf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // status
    assign sts.clr_last  = (32'(clr_cnt_reg) == 32'(MAP_WORDS - 1));
    assign sts.n_zero    = (n_reg == '0);
    assign sts.too_long  = (n_reg > size);
    assign sts.step_hit  = step_hit;
    assign sts.pass_end  = ((base_reg + PW'(8)) >= size);
    assign sts.word_end  = (base_reg[4:3] == 2'b11);
    assign sts.pass2     = pass_reg;
    assign sts.flip_last = (fw_reg == run_end[AW+4:5]);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= SIZE_RESET;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= in_kind;
            n_reg       <= PW'(in_run_length);
            hint_reg    <= (hint_ext >= size) ? '0 : hint_ext;
            widx_ok_reg <= widx_ok_live;
        end
        if (cmd.scan_init)
        begin
            pass_reg <= cmd.scan_pass;
            base_reg <= (cmd.scan_pass ? '0 : hint_reg) & ~PW'(7);
            run_reg  <= '0;
        end
        else if (cmd.byte_step)
        begin
            base_reg <= base_reg + PW'(8);
            run_reg  <= step_run;
            if (step_hit)
            begin
                hitpos_reg <= step_pos;
                fw_reg     <= step_pos[AW+4:5];
            end
        end
        else if (cmd.flip_wr)
        begin
            fw_reg <= fw_reg + AW'(1);
        end
        if (cmd.res_set)
        begin
            res_sel_reg <= cmd.res_sel;
        end
        if (cmd.out_load)
        begin
            found_reg <= 1'b0;
            start_reg <= '0;
            rword_reg <= '0;
            case (res_sel_reg)
                RES_READ:
                begin
                    rword_reg <= widx_ok_reg ? ram_rdata : '0;
                end
                RES_ROUND:
                begin
                    found_reg <= 1'b1;
                    start_reg <= hint_reg[START_W-1:0] & ~START_W'(7);
                end
                RES_RUN:
                begin
                    found_reg <= 1'b1;
                    start_reg <= hitpos_reg[START_W-1:0];
                end
                default:
                begin
                    found_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_found     = found_reg;
    assign out_run_start = start_reg;
    assign out_read_word = rword_reg;

endmodule

@@ hw/rtl/bitmap_run_find_and_flip_top.sv @@
// Top level of the bit map run finder with word access.
// The block keeps a MAP_BITS-bit allocation map in a RAM of 32-bit words and
// takes one item at a time. After reset a clearing pass writes zero to all
// MAP_BITS/32 words, one per cycle, before the first item is accepted. A
// write item writes the RAM when accepted and then loads the result register;
// a read item reads the RAM when accepted, then selects the read result and
// loads the read word into the result register. A find item scans the map
// one byte per cycle, with a RAM read state before each word, from the hint
// up to the size and then once more from zero; on a hit, each map word that
// the flipped run touches is read and then written back. The result register
// lets a finished result wait while the next item is accepted.
module bitmap_run_find_and_flip_top #(
    parameter int MAP_BITS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bmf_in_if.sink                    req,
    bmf_out_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [bmf_pkg::CFG_W-1:0] cfg_data
);
    import bmf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_kind   (req.kind),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bmf_dp #(
        .MAP_BITS (MAP_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_kind       (req.kind),
        .in_run_length (req.run_length),
        .in_hint       (req.hint),
        .in_word_index (req.word_index),
        .in_word_data  (req.word_data),
        .out_found     (rsp.found),
        .out_run_start (rsp.run_start),
        .out_read_word (rsp.read_word)
    );

endmodule
